// ===== rtl/cotangent_edge_weight_top_macros.svh =====
// Assertion macros for the cotangent edge weight block.
// Included by modules that carry concurrent assertions.
`ifndef COTANGENT_EDGE_WEIGHT_TOP_MACROS_SVH
`define COTANGENT_EDGE_WEIGHT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CEW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CEW_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CEW_ASSERT(label, clk, rst_n, prop, msg)
`define CEW_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/cew_pkg.sv =====
// Shared types and constants for the cotangent edge weight block.
// No dependencies.
package cew_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int DIFF_W = 33;
    localparam int SCL_W = 16;
    localparam int PROD_W = 34;
    localparam int N_W = 64;
    localparam int ROOT_W = 32;
    localparam int NUM_W = 34 + COORD_FRAC_BITS;
    localparam int Q_W = NUM_W;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic                last;
        logic                skip;
        logic                degen;
        logic                neg;
        logic [NUM_W-1:0]    num;
        logic [ROOT_W-1:0]   root;
    } cew_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIV
    } cew_state_t;

endpackage

// ===== rtl/cew_front.sv =====
// Front part: differences, normalizing shift, dot and cross products, square root.
// Depends on cew_pkg. Emits one job per item to the queue.
`include "cotangent_edge_weight_top_macros.svh"
module cew_front
    import cew_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [32*9-1:0]     in_coords,
    input  logic                in_last,
    input  logic                skip,
    output logic                job_valid,
    input  logic                job_ready,
    output cew_job_t            job
);

    cew_state_t state_reg, state_next;
    logic [DIFF_W-1:0] mag_reg [6];
    logic [5:0]        sgn_reg;
    logic              last_reg, skip_reg;
    logic signed [SCL_W:0] v [6];
    logic signed [SCL_W:0] v_reg [6];
    logic [5:0]        lz;
    logic [DIFF_W-1:0] mmax;
    logic signed [DIFF_W-1:0] d [6];
    logic signed [2*SCL_W+3:0] dot_c, cx, cy, cz;
    logic signed [2*SCL_W+3:0] dot_reg, cx_reg, cy_reg, cz_reg;
    logic [31:0]       ax, ay, az;
    logic [N_W-1:0]    n_c;
    logic [N_W-1:0]    rem_reg, rem_next;
    logic [N_W-1:0]    root_reg, root_next;
    logic [5:0]        it_reg, it_next;
    logic [NUM_W-1:0]  num_reg;
    logic              neg_reg, degen_reg;
    logic              m_zero;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d[k] = DIFF_W'($signed(in_coords[32*k +: 32]))
                 - DIFF_W'($signed(in_coords[32*(6+k) +: 32]));
            d[k+3] = DIFF_W'($signed(in_coords[32*(3+k) +: 32]))
                   - DIFF_W'($signed(in_coords[32*(6+k) +: 32]));
        end
    end

    // normalize from registered magnitudes
    always_comb
    begin
        mmax = '0;
        for (int k = 0; k < 6; k++)
            mmax = mmax | mag_reg[k];
        lz = 6'd0;
        for (int b = 0; b < DIFF_W; b++)
            if (mmax[b])
                lz = 6'(b);
        m_zero = (mmax == '0);
        for (int k = 0; k < 6; k++)
        begin
            logic [DIFF_W+SCL_W-1:0] s;
            s = {{SCL_W{1'b0}}, mag_reg[k]};
            if (lz >= 6'd14)
                s = s >> (lz - 6'd14);
            else
                s = s << (6'd14 - lz);
            v[k] = sgn_reg[k] ? -$signed({1'b0, s[SCL_W-1:0]}) : $signed({1'b0, s[SCL_W-1:0]});
        end
    end

    // dot and cross products from the registered scaled differences
    always_comb
    begin
        dot_c = (2*SCL_W+4)'(v_reg[0]) * (2*SCL_W+4)'(v_reg[3])
              + (2*SCL_W+4)'(v_reg[1]) * (2*SCL_W+4)'(v_reg[4])
              + (2*SCL_W+4)'(v_reg[2]) * (2*SCL_W+4)'(v_reg[5]);
        cx = (2*SCL_W+4)'(v_reg[1]) * (2*SCL_W+4)'(v_reg[5])
           - (2*SCL_W+4)'(v_reg[2]) * (2*SCL_W+4)'(v_reg[4]);
        cy = (2*SCL_W+4)'(v_reg[2]) * (2*SCL_W+4)'(v_reg[3])
           - (2*SCL_W+4)'(v_reg[0]) * (2*SCL_W+4)'(v_reg[5]);
        cz = (2*SCL_W+4)'(v_reg[0]) * (2*SCL_W+4)'(v_reg[4])
           - (2*SCL_W+4)'(v_reg[1]) * (2*SCL_W+4)'(v_reg[3]);
    end

    // squared cross length from the registered products
    always_comb
    begin
        ax = 32'(cx_reg[2*SCL_W+3] ? -cx_reg : cx_reg);
        ay = 32'(cy_reg[2*SCL_W+3] ? -cy_reg : cy_reg);
        az = 32'(cz_reg[2*SCL_W+3] ? -cz_reg : cz_reg);
        n_c = N_W'(ax) * N_W'(ax) + N_W'(ay) * N_W'(ay) + N_W'(az) * N_W'(az);
    end

    always_comb
    begin
        logic [N_W-1:0] bitv, t;
        state_next = state_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        it_next = it_reg;
        in_ready = 1'b0;
        job_valid = 1'b0;
        bitv = N_W'(1) << (2*it_reg);
        t = root_reg + bitv;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (it_reg > 6'd32)
                    it_next = it_reg - 6'd1;
                else if (it_reg == 6'd32)
                begin
                    rem_next = n_c;
                    root_next = '0;
                    it_next = 6'd31;
                end
                else
                begin
                    if (rem_reg >= t)
                    begin
                        rem_next = rem_reg - t;
                        root_next = (root_reg >> 1) + bitv;
                    end
                    else
                        root_next = root_reg >> 1;
                    if (it_reg == 6'd0)
                        state_next = ST_DIV;
                    else
                        it_next = it_reg - 6'd1;
                end
            end
            ST_DIV:
            begin
                job_valid = 1'b1;
                if (job_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            it_reg <= 6'd34;
        end
        else
        begin
            state_reg <= state_next;
            it_reg <= (state_reg == ST_IDLE) ? 6'd34 : it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            for (int k = 0; k < 6; k++)
            begin
                sgn_reg[k] <= d[k][DIFF_W-1];
                mag_reg[k] <= d[k][DIFF_W-1] ? -d[k] : d[k];
            end
            last_reg <= in_last;
            skip_reg <= skip;
        end
        if (state_reg == ST_SQRT && it_reg == 6'd34)
        begin
            for (int k = 0; k < 6; k++)
                v_reg[k] <= v[k];
        end
        if (state_reg == ST_SQRT && it_reg == 6'd33)
        begin
            dot_reg <= dot_c;
            cx_reg <= cx;
            cy_reg <= cy;
            cz_reg <= cz;
        end
        if (state_reg == ST_SQRT && it_reg == 6'd32)
        begin
            neg_reg <= dot_reg[2*SCL_W+3];
            num_reg <= NUM_W'(dot_reg[2*SCL_W+3] ? -dot_reg : dot_reg) << COORD_FRAC_BITS;
            degen_reg <= m_zero || (n_c == '0);
        end
    end

    always_comb
    begin
        job.last = last_reg;
        job.skip = skip_reg;
        job.degen = degen_reg;
        job.neg = neg_reg;
        job.num = num_reg;
        job.root = root_reg[ROOT_W-1:0];
    end

    `CEW_ASSERT(a_job_hold, clk, rst_n, job_valid && !job_ready |=> job_valid, "job dropped")
    `CEW_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> !job_valid, "front overlap")
    `CEW_ASSERT(a_it_range, clk, rst_n, state_reg == ST_DIV |-> it_reg == 6'd0, "sqrt count")

endmodule

// ===== rtl/cew_queue.sv =====
// Short job queue between front and back parts.
// Depends on cew_pkg.
`include "cotangent_edge_weight_top_macros.svh"
module cew_queue
    import cew_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  cew_job_t  wr_job,
    output logic      rd_valid,
    input  logic      rd_ready,
    output cew_job_t  rd_job
);

    cew_job_t mem [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign wr_ready = (cnt_reg != 3'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= wp_reg + 1'b1;
            if (rd_valid && rd_ready)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 3'(wr_valid && wr_ready) - 3'(rd_valid && rd_ready);
        end
    end

    `CEW_ASSERT(a_cnt_max, clk, rst_n, cnt_reg <= 3'(QDEPTH), "queue overflow")

endmodule

// ===== rtl/cew_back.sv =====
// Back part: restoring divide, saturation, edge accumulation and output register.
// Depends on cew_pkg.
`include "cotangent_edge_weight_top_macros.svh"
module cew_back
    import cew_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  cew_job_t    job,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_weight,
    output logic        out_degen,
    output logic        out_excess
);

    logic              busy_reg;
    logic [6:0]        it_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [ROOT_W:0]   r_reg;
    logic signed [32:0] sum_reg;
    logic [1:0]        cnt_reg;
    logic              dseen_reg;
    logic              ov_reg;
    logic [31:0]       w_reg;
    logic              dg_reg, ex_reg;
    logic [ROOT_W:0]   r_sh;
    logic signed [32:0] cot, sum_new;
    logic [33:0]       biased;
    logic              fin;
    logic              ov_set;

    assign job_ready = busy_reg && fin;
    assign out_weight = w_reg;
    assign out_degen = dg_reg;
    assign out_excess = ex_reg;
    assign r_sh = {r_reg[ROOT_W-1:0], q_reg[NUM_W-1]};
    assign fin = (it_reg == 7'(NUM_W)) && !(ov_reg && !out_ready);
    assign ov_set = busy_reg && fin && job.last;

    always_comb
    begin
        logic [NUM_W-1:0] qs;
        qs = job.neg ? ((q_reg > NUM_W'(33'h80000000)) ? NUM_W'(33'h80000000) : q_reg)
                     : ((q_reg > NUM_W'(32'h7FFFFFFF)) ? NUM_W'(32'h7FFFFFFF) : q_reg);
        cot = job.neg ? -$signed({1'b0, qs[31:0]}) : $signed({1'b0, qs[31:0]});
        if (job.neg && qs[32])
            cot = -33'sh80000000;
        sum_new = sum_reg;
        if (!job.skip && !job.degen)
            sum_new = sum_reg + cot;
        biased = 34'(sum_new) + 34'h100000000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            dseen_reg <= 1'b0;
            ov_reg <= 1'b0;
            w_reg <= '0;
            dg_reg <= 1'b0;
            ex_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_set || (ov_reg && !out_ready);
            if (!busy_reg && job_valid)
            begin
                busy_reg <= 1'b1;
                it_reg <= '0;
                q_reg <= job.num;
                r_reg <= '0;
            end
            else if (busy_reg && it_reg != 7'(NUM_W))
            begin
                if (r_sh >= {1'b0, job.root})
                begin
                    r_reg <= r_sh - {1'b0, job.root};
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= r_sh;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                it_reg <= it_reg + 7'd1;
            end
            else if (busy_reg && fin)
            begin
                busy_reg <= 1'b0;
                if (job.last)
                begin
                    w_reg <= 32'(biased[33:1] - 33'h80000000);
                    dg_reg <= dseen_reg || (!job.skip && job.degen);
                    ex_reg <= (cnt_reg == 2'd2) || (cnt_reg == 2'd3);
                    sum_reg <= '0;
                    cnt_reg <= '0;
                    dseen_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_new;
                    if (cnt_reg != 2'd3)
                        cnt_reg <= cnt_reg + 2'd1;
                    if (!job.skip && job.degen)
                        dseen_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid = ov_reg;

    `CEW_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_weight), "result lost")
    `CEW_ASSERT(a_it_bound, clk, rst_n, it_reg <= 7'(NUM_W), "divide count")

endmodule

// ===== rtl/cotangent_edge_weight_top.sv =====
// Cotangent edge weight: front (sqrt), queue, back (divide, accumulate).
// The front captures, scales, forms the products, loads the root and runs 32 root steps;
// the back part's 50-step divide sets the word rate. Front and back each take one word
// at a time, and the 4-deep queue between them absorbs the difference.
// rst_n asynchronous active low clears the accumulators, counters and queue.
`include "cotangent_edge_weight_top_macros.svh"
module cotangent_edge_weight_top
    import cew_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,  // end_i_x,y,z, end_j_x,y,z, opposite_x,y,z
    input  logic         s_axis_tlast,  // last_opposite
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // edge_weight
    output logic [1:0]   m_axis_tuser   // degenerate, excess_opposites
);

    logic [1:0] seen_reg;
    logic       f_valid, f_ready, b_valid, b_ready;
    cew_job_t   f_job, b_job;
    logic       dg, ex;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (s_axis_tvalid && s_axis_tready)
            seen_reg <= s_axis_tlast ? 2'd0 : ((seen_reg == 2'd2) ? 2'd2 : seen_reg + 2'd1);
    end

    cew_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_coords(s_axis_tdata), .in_last(s_axis_tlast),
        .skip(seen_reg == 2'd2),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    cew_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
    );

    cew_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_weight(m_axis_tdata), .out_degen(dg), .out_excess(ex)
    );

    assign m_axis_tuser = {ex, dg};

    `CEW_ASSERT(a_tuser_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser), "tuser changed")

endmodule
